// ===== rtl/mse_pkg.sv =====
// Shared constants for the merge sort engine.
package mse_pkg;

    // Default block capacity in elements.
    localparam int MSE_CAPACITY = 64;

    // Width of one element.
    localparam int MSE_DATA_W = 32;

    // Buffer bank codes.
    localparam logic BANK_STORE   = 1'b0;
    localparam logic BANK_SCRATCH = 1'b1;

endpackage

// ===== rtl/mse_mem.sv =====
// Element buffer bank: one write port, two registered read ports.
module mse_mem
    import mse_pkg::*;
#(
    parameter int DEPTH = MSE_CAPACITY,
    parameter int AW    = $clog2(MSE_CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [MSE_DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr0,
    input  logic [AW-1:0]         i_raddr1,
    output logic [MSE_DATA_W-1:0] o_rdata0,
    output logic [MSE_DATA_W-1:0] o_rdata1
);

    logic [MSE_DATA_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Both read ports are registered: data appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

// ===== rtl/mse_ctrl.sv =====
// Sequencer: loads a block, runs bottom-up merge passes between banks, streams out.
module mse_ctrl
    import mse_pkg::*;
#(
    parameter int CAPACITY = MSE_CAPACITY,
    parameter int AW       = $clog2(MSE_CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input request channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [MSE_DATA_W-1:0] i_in_value,
    input  logic                  i_in_last,
    // Output request channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [MSE_DATA_W-1:0] o_out_value,
    output logic                  o_out_last,
    output logic                  o_out_ovf,
    // Bank access.
    output logic                  o_wr_en,
    output logic                  o_wr_bank,
    output logic [AW-1:0]         o_wr_addr,
    output logic [MSE_DATA_W-1:0] o_wr_data,
    output logic [AW-1:0]         o_rd_addr0,
    output logic [AW-1:0]         o_rd_addr1,
    input  logic [MSE_DATA_W-1:0] i_st_rd0,
    input  logic [MSE_DATA_W-1:0] i_st_rd1,
    input  logic [MSE_DATA_W-1:0] i_sc_rd0,
    input  logic [MSE_DATA_W-1:0] i_sc_rd1
);

    // Count width holds CAPACITY itself; pointers get headroom for lo + 2 * width.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 2;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_MERGE = 3'd2;
    localparam logic [2:0] S_ORD   = 3'd3;
    localparam logic [2:0] S_OLD   = 3'd4;
    localparam logic [2:0] S_OWAIT = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_drop, n_drop;
    logic                  r_src, n_src;
    logic [PW-1:0]         r_width, n_width;
    logic [PW-1:0]         r_lo, n_lo;
    logic [PW-1:0]         r_mid, n_mid;
    logic [PW-1:0]         r_hi, n_hi;
    logic [PW-1:0]         r_i, n_i;
    logic [PW-1:0]         r_j, n_j;
    logic [PW-1:0]         r_k, n_k;
    logic                  r_out_valid, n_out_valid;
    logic [MSE_DATA_W-1:0] r_out_value, n_out_value;
    logic                  r_out_last, n_out_last;
    logic                  r_out_ovf, n_out_ovf;

    logic [PW-1:0]         w_n;
    logic [PW-1:0]         w_mid_raw;
    logic [PW-1:0]         w_hi_raw;
    logic [PW-1:0]         w_next_lo;
    logic [PW-1:0]         w_next_width;
    logic [CW-1:0]         w_count_inc;
    logic [MSE_DATA_W-1:0] w_head_a;
    logic [MSE_DATA_W-1:0] w_head_b;
    logic                  w_take_b;
    logic                  w_has_room;

    assign w_n          = {2'b00, r_count};
    assign w_mid_raw    = r_lo + r_width;
    assign w_hi_raw     = r_lo + (r_width << 1);
    assign w_next_lo    = r_lo + (r_width << 1);
    assign w_next_width = r_width << 1;
    assign w_has_room   = (r_count < CW'(CAPACITY));
    assign w_count_inc  = w_has_room ? (r_count + CW'(1)) : r_count;

    // Heads of the two runs come from the current source bank.
    assign w_head_a = (r_src == BANK_SCRATCH) ? i_sc_rd0 : i_st_rd0;
    assign w_head_b = (r_src == BANK_SCRATCH) ? i_sc_rd1 : i_st_rd1;

    // Take the right head when the left run is spent or the right head is smaller.
    assign w_take_b = (r_j < r_hi) &&
                      ((r_i >= r_mid) || ($signed(w_head_b) < $signed(w_head_a)));

    // Next-state and datapath logic.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_src       = r_src;
        n_width     = r_width;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        o_in_ready  = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_bank   = BANK_STORE;
        o_wr_addr   = r_count[AW-1:0];
        o_wr_data   = i_in_value;
        o_rd_addr0  = r_i[AW-1:0];
        o_rd_addr1  = r_j[AW-1:0];

        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_wr_en = w_has_room;
                    n_count = w_count_inc;
                    if (!w_has_room) begin
                        n_drop = 1'b1;
                    end
                    if (i_in_last) begin
                        n_src   = BANK_STORE;
                        n_width = PW'(1);
                        n_lo    = '0;
                        n_k     = '0;
                        // A single element needs no merge pass.
                        if (w_count_inc == CW'(1)) begin
                            n_state = S_ORD;
                        end else begin
                            n_state = S_SETUP;
                        end
                    end
                end
            end

            // Open a run pair and prefetch both heads.
            S_SETUP: begin
                n_mid      = (w_mid_raw > w_n) ? w_n : w_mid_raw;
                n_hi       = (w_hi_raw > w_n) ? w_n : w_hi_raw;
                n_i        = r_lo;
                n_j        = n_mid;
                n_k        = r_lo;
                o_rd_addr0 = n_i[AW-1:0];
                o_rd_addr1 = n_j[AW-1:0];
                n_state    = S_MERGE;
            end

            // One element per cycle into the destination bank.
            S_MERGE: begin
                o_wr_en   = 1'b1;
                o_wr_bank = ~r_src;
                o_wr_addr = r_k[AW-1:0];
                o_wr_data = w_take_b ? w_head_b : w_head_a;
                if (w_take_b) begin
                    n_j = r_j + PW'(1);
                end else begin
                    n_i = r_i + PW'(1);
                end
                n_k        = r_k + PW'(1);
                o_rd_addr0 = n_i[AW-1:0];
                o_rd_addr1 = n_j[AW-1:0];
                if (n_k == r_hi) begin
                    if (w_next_lo >= w_n) begin
                        // Pass complete: swap banks and double the run width.
                        n_src   = ~r_src;
                        n_width = w_next_width;
                        n_lo    = '0;
                        if (w_next_width >= w_n) begin
                            n_k     = '0;
                            n_state = S_ORD;
                        end else begin
                            n_state = S_SETUP;
                        end
                    end else begin
                        n_lo    = w_next_lo;
                        n_state = S_SETUP;
                    end
                end
            end

            // Fetch the next sorted element.
            S_ORD: begin
                o_rd_addr0 = r_k[AW-1:0];
                n_state    = S_OLD;
            end

            // Fill the output register.
            S_OLD: begin
                n_out_valid = 1'b1;
                n_out_value = w_head_a;
                n_out_last  = ((r_k + PW'(1)) == w_n);
                n_out_ovf   = r_drop;
                n_state     = S_OWAIT;
            end

            // Hold the result until the sink takes it; the block clears after the last.
            S_OWAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + PW'(1);
                        n_state = S_ORD;
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_src       <= BANK_STORE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_src       <= n_src;
            r_out_valid <= n_out_valid;
        end
    end

    // Pointer and payload registers.
    always_ff @(posedge i_clk) begin
        r_width     <= n_width;
        r_lo        <= n_lo;
        r_mid       <= n_mid;
        r_hi        <= n_hi;
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

// ===== rtl/merge_sort_engine_unit.sv =====
// After the last element, bottom-up merge passes run between the banks, with a setup
// step for each run pair of each pass; the sorted results then stream out one at a time.
// Throughput: one element per clock while loading; each sorted result is fetched and
// registered, then held until the sink takes it, before the next one is fetched.
// Reset: synchronous, active low; clears the element count, overflow flag and handshakes.
// The buffer banks hold no reset value; only entries written in the current block are read.
module merge_sort_engine_unit
    import mse_pkg::*;
#(
    parameter int CAPACITY = MSE_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] overflow
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int DEPTH = 1 << AW;

    logic                  w_wr_en;
    logic                  w_wr_bank;
    logic [AW-1:0]         w_wr_addr;
    logic [MSE_DATA_W-1:0] w_wr_data;
    logic [AW-1:0]         w_rd_addr0;
    logic [AW-1:0]         w_rd_addr1;
    logic [MSE_DATA_W-1:0] w_st_rd0;
    logic [MSE_DATA_W-1:0] w_st_rd1;
    logic [MSE_DATA_W-1:0] w_sc_rd0;
    logic [MSE_DATA_W-1:0] w_sc_rd1;
    logic                  w_st_we;
    logic                  w_sc_we;

    // Steer the single write to its bank.
    assign w_st_we = w_wr_en && (w_wr_bank == BANK_STORE);
    assign w_sc_we = w_wr_en && (w_wr_bank == BANK_SCRATCH);

    mse_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_value  (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_value (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_ovf   (m_axis_tuser),
        .o_wr_en     (w_wr_en),
        .o_wr_bank   (w_wr_bank),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr0  (w_rd_addr0),
        .o_rd_addr1  (w_rd_addr1),
        .i_st_rd0    (w_st_rd0),
        .i_st_rd1    (w_st_rd1),
        .i_sc_rd0    (w_sc_rd0),
        .i_sc_rd1    (w_sc_rd1)
    );

    // Element store bank.
    mse_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_st_we),
        .i_waddr  (w_wr_addr),
        .i_wdata  (w_wr_data),
        .i_raddr0 (w_rd_addr0),
        .i_raddr1 (w_rd_addr1),
        .o_rdata0 (w_st_rd0),
        .o_rdata1 (w_st_rd1)
    );

    // Merge scratch bank.
    mse_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_scratch (
        .i_clk    (i_clk),
        .i_we     (w_sc_we),
        .i_waddr  (w_wr_addr),
        .i_wdata  (w_wr_data),
        .i_raddr0 (w_rd_addr0),
        .i_raddr1 (w_rd_addr1),
        .o_rdata0 (w_sc_rd0),
        .o_rdata1 (w_sc_rd1)
    );

endmodule
